// ===== design/cpf_pkg.sv =====
// Shared types, constants and the byte-wise CRC-32 update for the packet framer.
package cpf_pkg;

	localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
	localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;
	localparam logic [7:0]  MarkS       = 8'h53;
	localparam logic [7:0]  MarkT       = 8'h54;
	localparam int          HeaderBytes = 18;
	localparam int          WordBits    = 32;
	localparam int          NumWordPorts = 7;

	typedef struct packed {
		logic load;
		logic emit_data;
		logic emit_crc;
	} cpf_cmd_t;

	typedef struct packed {
		logic data_last;
		logic crc_last;
	} cpf_sts_t;

	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'h0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== design/cpf_ctrl.sv =====
// Sequencing state machine of the packet framer: idle, data bytes, CRC bytes.
module cpf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cpf_pkg::cpf_sts_t sts,
	output cpf_pkg::cpf_cmd_t cmd,
	output logic             busy
);
	import cpf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DATA = 3'b010,
		ST_CRC  = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.emit_data = 1'b0;
		cmd.emit_crc  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DATA;
				end
			end
			ST_DATA: begin
				cmd.emit_data = 1'b1;
				if (sts.data_last) begin
					state_d = ST_CRC;
				end
			end
			ST_CRC: begin
				cmd.emit_crc = 1'b1;
				if (sts.crc_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== design/cpf_dpath.sv =====
// Datapath of the packet framer: frame shift register, CRC register and output word.
module cpf_dpath #(
	parameter int MAX_PAYLOAD_WORDS = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cpf_pkg::cpf_cmd_t cmd,
	output cpf_pkg::cpf_sts_t sts,
	input  logic              version_we,
	input  logic [7:0]        version_wdata,
	input  logic [7:0]        type_code,
	input  logic [31:0]       sequence_req,
	input  logic [63:0]       device_time,
	input  logic [2:0]        payload_words,
	input  logic [cpf_pkg::NumWordPorts-1:0][31:0] words_in,
	output logic [7:0]        frame_byte,
	output logic              end_of_frame,
	output logic              strobe
);
	import cpf_pkg::*;

	localparam int MaxBytes = HeaderBytes + 4 * MAX_PAYLOAD_WORDS;
	localparam int FrameW   = 8 * MaxBytes;
	localparam int CntW     = $clog2(MaxBytes);

	logic [7:0]        version_q;
	logic [FrameW-1:0] shift_q;
	logic [FrameW-1:0] frame_load;
	logic [CntW-1:0]   rem_q;
	logic [1:0]        crc_idx_q;
	logic [31:0]       crc_q;
	logic [7:0]        byte_q;
	logic              eof_q;
	logic              strobe_q;
	logic [2:0]        words_sat;
	logic [15:0]       length_bytes;

	// Counts above the configured maximum are clamped; length and payload follow.
	assign words_sat = (payload_words > 3'(MAX_PAYLOAD_WORDS)) ?
		3'(MAX_PAYLOAD_WORDS) : payload_words;
	assign length_bytes = {11'h0, words_sat, 2'b00};

	// The whole frame body is laid out least significant byte first.
	always_comb begin
		frame_load = '0;
		frame_load[8*HeaderBytes-1:0] = {device_time, sequence_req, length_bytes,
			type_code, version_q, MarkT, MarkS};
		for (int i = 0; i < MAX_PAYLOAD_WORDS; i++) begin
			frame_load[8*HeaderBytes + WordBits*i +: WordBits] = words_in[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= 8'd1;
		end else if (version_we) begin
			version_q <= version_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			crc_idx_q <= '0;
			strobe_q  <= 1'b0;
			eof_q     <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_data | cmd.emit_crc;
			eof_q    <= cmd.emit_crc & (crc_idx_q == 2'd3);
			if (cmd.load) begin
				rem_q     <= CntW'(HeaderBytes - 1) + CntW'({words_sat, 2'b00});
				crc_idx_q <= '0;
			end else begin
				if (cmd.emit_data) begin
					rem_q <= rem_q - 1'b1;
				end
				if (cmd.emit_crc) begin
					crc_idx_q <= crc_idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shift_q <= frame_load;
			crc_q   <= CrcInit;
		end else if (cmd.emit_data) begin
			shift_q <= shift_q >> 8;
			crc_q   <= crc_feed(crc_q, shift_q[7:0]);
			byte_q  <= shift_q[7:0];
		end else if (cmd.emit_crc) begin
			// The trailer goes out inverted, low byte first.
			crc_q  <= crc_q >> 8;
			byte_q <= ~crc_q[7:0];
		end
	end

	assign sts.data_last = (rem_q == '0);
	assign sts.crc_last  = (crc_idx_q == 2'd3);

	assign frame_byte   = byte_q;
	assign end_of_frame = eof_q;
	assign strobe       = strobe_q;

endmodule

// ===== design/crc32_packet_framer_top.sv =====
// Top level of the CRC-32 packet framer: controller and datapath.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------------
//  packet   | start in, busy out         | type_code, sequence_req, device_time,
//           |                            | payload_words, word_0 .. word_6
//  frame    | strobe out                 | frame_byte, end_of_frame
//  config   | version_we in              | version_wdata
//
// A packet word is taken at a clock edge with start high and busy low.
// It then gives 22 + 4 * words frame bytes, one per cycle, the first one after the
// state register and then the output byte register; busy falls with the last byte,
// so a new packet is taken only once the last byte of the one before is out. The
// pace is set by the byte-wide CRC update and the single output byte register.
// Reset clears the sequencer and sets the version byte to 1. The receiver cannot
// stall: each byte is valid for exactly the one cycle that strobe is high.
module crc32_packet_framer_top #(
	parameter int MAX_PAYLOAD_WORDS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  type_code,
	input  logic [31:0] sequence_req,
	input  logic [63:0] device_time,
	input  logic [2:0]  payload_words,
	input  logic [31:0] word_0,
	input  logic [31:0] word_1,
	input  logic [31:0] word_2,
	input  logic [31:0] word_3,
	input  logic [31:0] word_4,
	input  logic [31:0] word_5,
	input  logic [31:0] word_6,
	input  logic        version_we,
	input  logic [7:0]  version_wdata,
	output logic [7:0]  frame_byte,
	output logic        end_of_frame,
	output logic        strobe
);
	import cpf_pkg::*;

	cpf_cmd_t cmd;
	cpf_sts_t sts;
	logic [NumWordPorts-1:0][31:0] words_in;

	assign words_in = {word_6, word_5, word_4, word_3, word_2, word_1, word_0};

	cpf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	cpf_dpath #(
		.MAX_PAYLOAD_WORDS (MAX_PAYLOAD_WORDS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.version_we    (version_we),
		.version_wdata (version_wdata),
		.type_code     (type_code),
		.sequence_req  (sequence_req),
		.device_time   (device_time),
		.payload_words (payload_words),
		.words_in      (words_in),
		.frame_byte    (frame_byte),
		.end_of_frame  (end_of_frame),
		.strobe        (strobe)
	);

endmodule
